// ----- hdl/z_ordered_rect_hit_table_defines.svh -----
// ----------------------------------------------------------------------------
// z_ordered_rect_hit_table_defines
// assertion macros used by the rect hit table checker
// ----------------------------------------------------------------------------
`ifndef Z_ORDERED_RECT_HIT_TABLE_DEFINES_SVH
`define Z_ORDERED_RECT_HIT_TABLE_DEFINES_SVH

// property checked only outside reset
`define ZORHT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("zorht check failed");

// property checked on every edge, reset included
`define ZORHT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("zorht reset check failed");

`endif

// ----- hdl/zorht_pkg.sv -----
// ----------------------------------------------------------------------------
// zorht_pkg
// shared types and constants of the z-ordered rect hit table
// ----------------------------------------------------------------------------
package zorht_pkg;

    localparam int SLOT_W   = 7;
    localparam int IN_DW    = 128;
    localparam int OUT_DW   = 24;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_QRY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // one table entry; a query token keeps its point in left/top
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] order;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] top;
        logic [15:0] left;
    } t_ent;

    // wave that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic              vld;
        logic              qry;
        logic              done;
        logic [SLOT_W-1:0] slot;
        t_ent              ent;
    } t_tok;

endpackage

// ----- hdl/zorht_cell.sv -----
// ----------------------------------------------------------------------------
// zorht_cell
// one table slot: stores an entry and passes the wave to the next slot
// ----------------------------------------------------------------------------
module zorht_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  zorht_pkg::t_tok  i_tok,
    input  logic [CNT_W-1:0] i_cnt,
    output zorht_pkg::t_tok  o_tok
);

    localparam logic [CNT_W-1:0]             IDX_C  = CNT_W'(IDX);
    localparam logic [zorht_pkg::SLOT_W-1:0] SLOT_C = zorht_pkg::SLOT_W'(IDX);

    zorht_pkg::t_ent r_ent;
    zorht_pkg::t_ent n_ent;
    zorht_pkg::t_tok r_tok;
    zorht_pkg::t_tok n_tok;
    logic            w_valid;
    logic            w_at_end;
    logic            w_le;
    logic            w_hit;

    // half-open containment test on sign-extended edges
    function automatic logic holds(zorht_pkg::t_ent e, logic [15:0] px, logic [15:0] py);
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] l;
        logic signed [17:0] t;
        logic signed [17:0] r;
        logic signed [17:0] b;
        x = {{2{px[15]}}, px};
        y = {{2{py[15]}}, py};
        l = {{2{e.left[15]}}, e.left};
        t = {{2{e.top[15]}}, e.top};
        r = l + {2'b00, e.width};
        b = t + {2'b00, e.height};
        return (x >= l) && (x < r) && (y >= t) && (y < b);
    endfunction

    assign w_valid  = IDX_C < i_cnt;
    assign w_at_end = IDX_C == i_cnt;
    assign w_le     = $signed(r_ent.order) <= $signed(i_tok.ent.order);
    assign w_hit    = holds(r_ent, i_tok.ent.left, i_tok.ent.top);

    always_comb begin
        n_ent = r_ent;
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.qry) begin
            if (w_valid) begin
                if (i_tok.done || w_le) begin
                    // swap: carried entry lands here, old one moves on
                    n_ent     = i_tok.ent;
                    n_tok.ent = r_ent;
                    if (!i_tok.done) begin
                        n_tok.done = 1'b1;
                        n_tok.slot = SLOT_C;
                    end
                end
            end else if (w_at_end) begin
                n_ent = i_tok.ent;
                if (!i_tok.done) begin
                    n_tok.slot = SLOT_C;
                end
                n_tok.done = 1'b1;
            end
        end else if (i_tok.vld && i_tok.qry) begin
            if (w_valid && !i_tok.done && w_hit) begin
                n_tok.done    = 1'b1;
                n_tok.slot    = SLOT_C;
                n_tok.ent.tag = r_ent.tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- hdl/z_ordered_rect_hit_table.sv -----
// ----------------------------------------------------------------------------
// z_ordered_rect_hit_table
// rectangle table sorted by descending draw order with point hit queries
// ----------------------------------------------------------------------------
// an add or query beat enters the wave register, crosses the cell chain one
// cell per cycle and lands in the output register; only one item is in
// flight at a time, so no new beat is taken until the wave exits
// an add into a full table answers in the cycle after it is taken
// reset (synchronous, active low) empties the table and drops any wave
// ----------------------------------------------------------------------------
module z_ordered_rect_hit_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // rect_left, rect_top, rect_width, rect_height, draw_order, entry_tag,
    // point_x, point_y (16 bits each, lowest bits first)
    input  logic [zorht_pkg::IN_DW-1:0]  s_tdata,
    // func
    input  logic                         s_tuser,
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // slot [6:0], found [7], found_tag [23:8]
    output logic [zorht_pkg::OUT_DW-1:0] m_tdata,
    // status
    output logic                         m_tuser
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // wave taps between cells: tap i feeds cell i, tap MAX_ENTRIES is the exit
    zorht_pkg::t_tok w_tap [0:MAX_ENTRIES];

    zorht_pkg::t_tok r_tok0;
    zorht_pkg::t_tok n_tok0;
    logic [CNT_W-1:0] r_cnt;
    logic            r_busy;
    logic            r_out_vld;
    logic            r_out_status;
    logic [zorht_pkg::SLOT_W-1:0] r_out_slot;
    logic            r_out_found;
    logic [15:0]     r_out_tag;
    logic            w_take;
    logic            w_full;
    logic            w_refuse;
    logic            w_exit;
    logic            w_hit;

    // one item in flight; the output register is free by the time its
    // result arrives because it is being drained when the beat is taken
    assign s_tready = !r_busy && (!r_out_vld || m_tready);
    assign w_take   = s_tvalid && s_tready;
    assign w_full   = r_cnt == CNT_W'(MAX_ENTRIES);
    assign w_refuse = w_take && (s_tuser == zorht_pkg::FUNC_ADD) && w_full;

    // build the entering wave; a query carries its point in left/top
    always_comb begin
        n_tok0            = r_tok0;
        n_tok0.vld        = w_take && !w_refuse;
        n_tok0.qry        = s_tuser == zorht_pkg::FUNC_QRY;
        n_tok0.done       = 1'b0;
        n_tok0.slot       = '0;
        n_tok0.ent.left   = n_tok0.qry ? s_tdata[111:96]  : s_tdata[15:0];
        n_tok0.ent.top    = n_tok0.qry ? s_tdata[127:112] : s_tdata[31:16];
        n_tok0.ent.width  = s_tdata[47:32];
        n_tok0.ent.height = s_tdata[63:48];
        n_tok0.ent.order  = s_tdata[79:64];
        n_tok0.ent.tag    = n_tok0.qry ? 16'd0 : s_tdata[95:80];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.vld <= 1'b0;
        end else if (w_take) begin
            r_tok0 <= n_tok0;
        end else begin
            r_tok0.vld <= 1'b0;
        end
    end

    assign w_tap[0] = r_tok0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            zorht_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tap[gi]),
                .i_cnt   (r_cnt),
                .o_tok   (w_tap[gi+1])
            );
        end
    endgenerate

    // wave leaves the last cell: result is final
    assign w_exit = w_tap[MAX_ENTRIES].vld;
    assign w_hit  = w_tap[MAX_ENTRIES].qry && w_tap[MAX_ENTRIES].done;

    // busy from a taken beat that is not refused until the wave exits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_take && !w_refuse) begin
            r_busy <= 1'b1;
        end else if (w_exit) begin
            r_busy <= 1'b0;
        end
    end

    // entry count moves only when an add wave completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_exit && !w_tap[MAX_ENTRIES].qry) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_refuse || w_exit) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_refuse) begin
            r_out_status <= zorht_pkg::STATUS_FULL;
            r_out_slot   <= '0;
            r_out_found  <= 1'b0;
            r_out_tag    <= '0;
        end else if (w_exit) begin
            // add waves are always done; a missed query reports slot 0
            r_out_status <= zorht_pkg::STATUS_OK;
            r_out_slot   <= w_tap[MAX_ENTRIES].done ? w_tap[MAX_ENTRIES].slot : '0;
            r_out_found  <= w_hit;
            r_out_tag    <= w_hit ? w_tap[MAX_ENTRIES].ent.tag : 16'd0;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {r_out_tag, r_out_found, r_out_slot};

endmodule

// ----- hdl/zorht_checker.sv -----
// ----------------------------------------------------------------------------
// zorht_checker
// port-level checks of the rect hit table, bound to the top level
// ----------------------------------------------------------------------------
`include "z_ordered_rect_hit_table_defines.svh"

module zorht_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [zorht_pkg::IN_DW-1:0]  s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [zorht_pkg::OUT_DW-1:0] m_tdata,
    input logic                         m_tuser
);

    // no result beat right after reset
    `ZORHT_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_tvalid)

    // stalled result beat holds
    `ZORHT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a refused add carries an all-zero payload
    `ZORHT_ASSERT(a_full_zero, m_tvalid && m_tuser |-> m_tdata == '0)

    // a tag shows only with a hit
    `ZORHT_ASSERT(a_tag_hit, m_tvalid && !m_tdata[7] |-> m_tdata[23:8] == 16'd0)

    // no new beat taken while a result is stuck at the output
    `ZORHT_ASSERT(a_no_take_stall, m_tvalid && !m_tready |-> !s_tready)

endmodule

bind z_ordered_rect_hit_table zorht_checker u_zorht_checker (.*);

// ----- bench/z_ordered_rect_hit_table_checker.sv -----
// ----------------------------------------------------------------------------
// z_ordered_rect_hit_table_checker
// watches both stream channels, keeps its own copy of the sorted rect table
// and compares every answer beat with the answer the table predicts
// ----------------------------------------------------------------------------
module z_ordered_rect_hit_table_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // rect_left, rect_top, rect_width, rect_height, draw_order, entry_tag,
    // point_x, point_y (16 bits each, lowest bits first)
    input  logic [zorht_pkg::IN_DW-1:0]  i_s_tdata,
    // func
    input  logic                         i_s_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    // slot, found, found_tag (lowest bits first)
    input  logic [zorht_pkg::OUT_DW-1:0] i_m_tdata,
    // status
    input  logic                         i_m_tuser,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [15:0] point_y;
        logic [15:0] point_x;
        logic [15:0] tag;
        logic [15:0] order;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] top;
        logic [15:0] left;
    } t_rect_item;

    // laid out so that {m_tuser, m_tdata} casts straight onto it
    typedef struct packed {
        logic                         status;
        logic [15:0]                  tag;
        logic                         found;
        logic [zorht_pkg::SLOT_W-1:0] slot;
    } t_hit_answer;

    logic [15:0] tbl_left   [MAX_ENTRIES];
    logic [15:0] tbl_top    [MAX_ENTRIES];
    logic [15:0] tbl_width  [MAX_ENTRIES];
    logic [15:0] tbl_height [MAX_ENTRIES];
    logic [15:0] tbl_order  [MAX_ENTRIES];
    logic [15:0] tbl_tag    [MAX_ENTRIES];
    int          tbl_count;

    t_hit_answer due_answers[$];
    int          mismatch_cnt = 0;

    // updates the table for one item and returns the answer it must produce
    function automatic t_hit_answer apply_item(logic func, t_rect_item it);
        t_hit_answer ans;
        int          pos;
        int          i;
        int          px;
        int          py;
        int          l;
        int          t;
        int          w;
        int          h;
        ans = '0;
        if (func == zorht_pkg::FUNC_ADD) begin
            if (tbl_count >= MAX_ENTRIES) begin
                ans.status = zorht_pkg::STATUS_FULL;
            end else begin
                // first entry whose order is not above the new one; scanning
                // backward leaves the lowest such slot
                pos = tbl_count;
                for (i = tbl_count - 1; i >= 0; i--) begin
                    if ($signed(tbl_order[i]) <= $signed(it.order))
                        pos = i;
                end
                for (i = tbl_count; i > pos; i--) begin
                    tbl_left[i]   = tbl_left[i-1];
                    tbl_top[i]    = tbl_top[i-1];
                    tbl_width[i]  = tbl_width[i-1];
                    tbl_height[i] = tbl_height[i-1];
                    tbl_order[i]  = tbl_order[i-1];
                    tbl_tag[i]    = tbl_tag[i-1];
                end
                tbl_left[pos]   = it.left;
                tbl_top[pos]    = it.top;
                tbl_width[pos]  = it.width;
                tbl_height[pos] = it.height;
                tbl_order[pos]  = it.order;
                tbl_tag[pos]    = it.tag;
                tbl_count++;
                ans.slot = pos[zorht_pkg::SLOT_W-1:0];
            end
        end else begin
            px = $signed(it.point_x);
            py = $signed(it.point_y);
            // half-open box test in 32-bit math so edges near the 16-bit limits hold
            for (i = tbl_count - 1; i >= 0; i--) begin
                l = $signed(tbl_left[i]);
                t = $signed(tbl_top[i]);
                w = tbl_width[i];
                h = tbl_height[i];
                if (px >= l && px < l + w && py >= t && py < t + h) begin
                    ans.found = 1'b1;
                    ans.slot  = i[zorht_pkg::SLOT_W-1:0];
                    ans.tag   = tbl_tag[i];
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_hit_answer got;
        t_hit_answer want;
        if (!i_rst_n) begin
            tbl_count = 0;
            due_answers.delete();
        end else begin
            // answer first: a beat taken on this edge cannot answer yet
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser, i_m_tdata};
                if (due_answers.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display({"[%0t] answer beat with none outstanding: ",
                                  "status %0b slot %0d found %0b tag %h"},
                                 $time, got.status, got.slot, got.found, got.tag);
                    mismatch_cnt++;
                end else begin
                    want = due_answers.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.found !== want.found || got.tag !== want.tag) begin
                        if (mismatch_cnt < 10)
                            $display({"[%0t] answer mismatch (exp/got): status %0b/%0b ",
                                      "slot %0d/%0d found %0b/%0b tag %h/%h"},
                                     $time, want.status, got.status, want.slot, got.slot,
                                     want.found, got.found, want.tag, got.tag);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                due_answers.push_back(apply_item(i_s_tuser, i_s_tdata));
        end
        o_pending    <= due_answers.size();
        o_fail_count <= mismatch_cnt + due_answers.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives adds and point queries into the rect hit table with random idling
// on both channels; a checker beside the block predicts every answer beat
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_ENTRIES = 64;
    localparam int N_RANDOM    = 580;
    // the idle limit covers one beat's walk through the table plus stalls on either side
    localparam int IDLE_LIMIT  = 1000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [zorht_pkg::IN_DW-1:0]   s_tdata;   // rect_left .. point_y, 16 bits each
    logic                          s_tuser;   // func
    logic                          m_tvalid;
    logic                          m_tready;
    logic [zorht_pkg::OUT_DW-1:0]  m_tdata;   // slot, found, found_tag
    logic                          m_tuser;   // status

    int                  fail_count;
    int                  pending;
    int                  adds_sent  = 0;
    int                  beats_sent = 0;
    bit                  calm_tail  = 1'b0;   // no idling near the end
    int                  idle_cycles = 0;

    z_ordered_rect_hit_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    z_ordered_rect_hit_table_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random value in [lo, hi], truncated to a 16-bit field
    function automatic logic [15:0] near_coord(int lo, int hi);
        int v;
        v = int'($urandom_range(0, hi - lo)) + lo;
        return v[15:0];
    endfunction

    // sender idles a burst now and then; sometimes it first waits for the
    // answer beat of the last item so the gap lands late in the block's walk
    task automatic sender_idle();
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            if (beats_sent > 0 && $urandom_range(0, 1) == 0) begin
                @(posedge i_clk);
                while (!(m_tvalid && m_tready)) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // holds the beat until it is taken; valid stays high for the caller
    task automatic push_beat(input logic func, input logic [zorht_pkg::IN_DW-1:0] data);
        s_tuser  <= func;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // point fields of an add are don't-care, so they carry random bits
    task automatic add_rect(input logic [15:0] l, t, w, h, ord, tg);
        logic [15:0] junk_x;
        logic [15:0] junk_y;
        junk_x = 16'($urandom);
        junk_y = 16'($urandom);
        sender_idle();
        push_beat(zorht_pkg::FUNC_ADD, {junk_y, junk_x, tg, ord, h, w, t, l});
        adds_sent++;
    endtask

    // rect fields of a query are don't-care as well
    task automatic query_point(input logic [15:0] px, py);
        logic [zorht_pkg::IN_DW-1:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom};
        sender_idle();
        push_beat(zorht_pkg::FUNC_QRY, {py, px, junk[95:0]});
    endtask

    // random rect: mostly small boxes around the origin so queries hit often,
    // a share with fully random fields to swing every bit
    task automatic random_add();
        logic [15:0] l, t, w, h, ord, tg;
        tg = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            l = near_coord(-40, 40);
            t = near_coord(-40, 40);
            w = ($urandom_range(0, 7) == 0) ? 16'h0000 : near_coord(1, 48);
            h = ($urandom_range(0, 7) == 0) ? 16'h0000 : near_coord(1, 48);
        end else begin
            l = 16'($urandom);
            t = 16'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end
        // small order range makes ties, which test newest-first placement
        case ($urandom_range(0, 4))
            0:       ord = 16'($urandom);
            1:       ord = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: ord = near_coord(-3, 3);
        endcase
        add_rect(l, t, w, h, ord, tg);
    endtask

    task automatic random_query();
        logic [15:0] px, py;
        case ($urandom_range(0, 9))
            0: begin
                px = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                py = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            1, 2: begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            default: begin
                px = near_coord(-60, 100);
                py = near_coord(-60, 100);
            end
        endcase
        query_point(px, py);
    endtask

    // receiver: ready in runs of random length, broken by stall bursts
    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm_tail && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 120)) @(posedge i_clk);
        end
    end

    // watchdog: too long with no beat on either channel ends the run
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= zorht_pkg::FUNC_ADD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extreme boxes, zero-size boxes, order ties
        query_point(16'h0000, 16'h0000);                          // empty table
        add_rect(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        query_point(16'h8000, 16'h8000);                          // lowest corner
        query_point(16'h7FFE, 16'h7FFE);                          // last point inside
        query_point(16'h7FFF, 16'h0000);                          // right edge is open
        add_rect(16'h7FFF, 16'h7FFF, 16'h0001, 16'h0001, 16'h7FFF, 16'h0001);
        query_point(16'h7FFF, 16'h7FFF);
        add_rect(16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'h7FFF, 16'h0002); // zero width
        add_rect(16'h0000, 16'h0000, 16'h0064, 16'h0000, 16'h8000, 16'h0003); // zero height
        query_point(16'h0000, 16'h0000);
        add_rect(16'h0000, 16'h0000, 16'h000A, 16'h000A, 16'h0000, 16'h0004); // ties big box
        query_point(16'h0005, 16'h0005);
        query_point(16'h000A, 16'h000A);
        query_point(16'hFFFF, 16'hFFFF);
        add_rect(16'hFFF6, 16'hFFF6, 16'h0014, 16'h0014, 16'h8000, 16'h0005); // lowest tie
        query_point(16'hFFF6, 16'hFFF6);
        add_rect(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFE, 16'h0006);
        query_point(16'h7FFF, 16'h7FFF);
        query_point(16'h8000, 16'h7FFF);
        query_point(16'h0000, 16'h8000);

        // random: an even mix of adds and queries until the table is full, then
        // mostly queries and refused adds against a full table
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k >= N_RANDOM * 85 / 100)
                calm_tail = 1'b1;
            if ($urandom_range(0, 99) < ((adds_sent < MAX_ENTRIES + 4) ? 50 : 15))
                random_add();
            else
                random_query();
        end
        s_tvalid <= 1'b0;

        // drain outstanding answers, then give the block one more walk
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
